>>> hw/rtl/gfs_pkg.sv
package gfs_pkg;

  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 128;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // request codes on req_type
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SPAN  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SPAN,
    OP_CLEAR
  } op_e;

  // queued command; x/y already known to be in range for writes,
  // last already clipped for spans
  typedef struct packed {
    op_e        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] level;
    logic [6:0] row;
    logic [5:0] first;
    logic [5:0] last;
  } cmd_t;

  typedef logic [3:0][3:0] grey_map_t;

  localparam grey_map_t GREY_RESET = {4'd15, 4'd8, 4'd1, 4'd0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SPAN,
    ST_CLEAR
  } back_state_e;

  typedef struct packed {
    logic init_clear;
  } back_status_t;

endpackage

>>> hw/rtl/gfs_front.sv
module gfs_front import gfs_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   req_type_i,
  input  logic [8:0]   pixel_x_i,
  input  logic [8:0]   pixel_y_i,
  input  logic [7:0]   pixel_level_i,
  input  logic [6:0]   span_row_i,
  input  logic [5:0]   first_column_i,
  input  logic [5:0]   last_column_i,
  input  logic         queue_full_i,
  input  back_status_t back_status_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  localparam int unsigned SPAN_COLUMNS = (FRAME_WIDTH + 1) / 2;

  logic [5:0] last_clip;
  logic       keep;

  assign last_clip = ({2'b00, last_column_i} > 8'(SPAN_COLUMNS - 1)) ?
                     6'(SPAN_COLUMNS - 1) : last_column_i;

  always_comb begin
    cmd_o.op    = OP_CLEAR;
    cmd_o.x     = pixel_x_i[7:0];
    cmd_o.y     = pixel_y_i[7:0];
    cmd_o.level = pixel_level_i[1:0];
    cmd_o.row   = span_row_i;
    cmd_o.first = first_column_i;
    cmd_o.last  = last_clip;
    keep        = 1'b0;
    unique case (req_type_i)
      REQ_WRITE: begin
        cmd_o.op = OP_WRITE;
        keep     = !pixel_x_i[8] && !pixel_y_i[8] && !pixel_level_i[7] &&
                   ({1'b0, pixel_x_i[7:0]} < 9'(FRAME_WIDTH)) &&
                   ({1'b0, pixel_y_i[7:0]} < 9'(FRAME_HEIGHT));
      end
      REQ_SPAN: begin
        cmd_o.op = OP_SPAN;
        keep     = ({2'b00, span_row_i} < 9'(FRAME_HEIGHT)) &&
                   (first_column_i <= last_clip);
      end
      REQ_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy   = queue_full_i | back_status_i.init_clear;
  assign push_o = start & ~busy & keep;

endmodule

>>> hw/rtl/gfs_queue.sv
module gfs_queue import gfs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> hw/rtl/gfs_back.sv
module gfs_back import gfs_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  cmd_t         cmd_i,
  input  grey_map_t    grey_map_i,
  output logic         pop_o,
  output back_status_t status_o,
  output logic [7:0]   grey_byte_o,
  output logic         byte_last_o,
  output logic         grey_strobe_o
);

  localparam int unsigned WORDS_PER_ROW = (FRAME_WIDTH + 7) / 8;
  localparam int unsigned DEPTH         = WORDS_PER_ROW * FRAME_HEIGHT;
  localparam int unsigned ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_e state_q, state_d;

  logic [5:0]        col_q, col_d;
  logic [5:0]        last_q, last_d;
  logic [6:0]        row_q, row_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [2:0]        pix_q, pix_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              init_q, init_d;

  logic [15:0]       frame_mem_q [DEPTH];
  logic [15:0]       rd_data_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              issue;

  logic              p1_valid_q;
  logic [1:0]        p1_nib_q;
  logic              p1_last_q;

  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] span_addr;
  logic [15:0]       merge_mask;
  logic [15:0]       merge_bits;
  logic [3:0]        pair;

  // word (x/8) of row y lives at (x/8)*FRAME_HEIGHT + y
  assign pix_addr  = ADDR_W'(cmd_i.x[7:3]) * ADDR_W'(FRAME_HEIGHT) + ADDR_W'(cmd_i.y);
  assign span_addr = ADDR_W'(col_q[5:2]) * ADDR_W'(FRAME_HEIGHT) + ADDR_W'(row_q);

  assign merge_mask = 16'(2'b11) << {pix_q, 1'b0};
  assign merge_bits = 16'(lvl_q) << {pix_q, 1'b0};

  assign status_o.init_clear = init_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (cmd_i.op)
            OP_WRITE: state_d = ST_MERGE;
            OP_SPAN:  state_d = ST_SPAN;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MERGE: state_d = ST_IDLE;
      ST_SPAN: begin
        if (col_q == last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = span_addr;
    we         = 1'b0;
    waddr      = clr_addr_q;
    wdata      = '0;
    issue      = 1'b0;
    col_d      = col_q;
    last_d     = last_q;
    row_d      = row_q;
    wr_addr_d  = wr_addr_q;
    pix_d      = pix_q;
    lvl_d      = lvl_q;
    clr_addr_d = clr_addr_q;
    init_d     = init_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_WRITE: begin
              rd_en     = 1'b1;
              rd_addr   = pix_addr;
              wr_addr_d = pix_addr;
              pix_d     = cmd_i.x[2:0];
              lvl_d     = cmd_i.level;
            end
            OP_SPAN: begin
              col_d  = cmd_i.first;
              last_d = cmd_i.last;
              row_d  = cmd_i.row;
            end
            OP_CLEAR: begin
              clr_addr_d = '0;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_MERGE: begin
        we    = 1'b1;
        waddr = wr_addr_q;
        wdata = (rd_data_q & ~merge_mask) | merge_bits;
      end
      ST_SPAN: begin
        rd_en   = 1'b1;
        rd_addr = span_addr;
        issue   = 1'b1;
        col_d   = col_q + 1'b1;
      end
      ST_CLEAR: begin
        we         = 1'b1;
        waddr      = clr_addr_q;
        wdata      = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          init_d = 1'b0;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      init_q     <= 1'b1;
      p1_valid_q <= 1'b0;
      grey_strobe_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      init_q     <= init_d;
      p1_valid_q <= issue;
      grey_strobe_o <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    last_q    <= last_d;
    row_q     <= row_d;
    wr_addr_q <= wr_addr_d;
    pix_q     <= pix_d;
    lvl_q     <= lvl_d;
    p1_nib_q  <= col_q[1:0];
    p1_last_q <= (col_q == last_q);
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      frame_mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= frame_mem_q[rd_addr];
    end
  end

  // grey lookup and output register
  assign pair = rd_data_q[{p1_nib_q, 2'b00} +: 4];

  always_ff @(posedge clk_i) begin
    grey_byte_o <= {grey_map_i[pair[3:2]], grey_map_i[pair[1:0]]};
    byte_last_o <= p1_last_q;
  end

endmodule

>>> hw/rtl/greyscale_frame_store.sv
// Frame store of FRAME_WIDTH x FRAME_HEIGHT 2-bit pixels, eight to a 16-bit
// word, read out as 4-bit greyscale through four programmable level nibbles
// (APB registers at 0x0, 0x4, 0x8, 0xC). A transaction is taken when start
// is high and busy is low; busy rises only when the two-entry command queue
// is full or during the clearing pass after reset, which writes every word of the
// memory in turn ((FRAME_WIDTH+7)/8 * FRAME_HEIGHT words, 2048 at the
// default size). Results cannot be stalled: each byte appears for exactly one
// cycle with grey_strobe_o high and must be captured then. Execution is
// shaped by the one write port and one registered read port of the frame
// memory: a pixel write is a read-modify-write, a span delivers its bytes
// back to back, one per cycle, each through the read data register and the
// output register after its memory read; a clear request sweeps the memory
// word by word. Commands execute strictly in the order accepted, so a
// span always sees every earlier write. Rejected writes, empty spans and
// unused request codes are dropped at the front and cost nothing.
module greyscale_frame_store import gfs_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic [7:0]  pixel_level_i,
  input  logic [6:0]  span_row_i,
  input  logic [5:0]  first_column_i,
  input  logic [5:0]  last_column_i,
  // result channel
  output logic [7:0]  grey_byte_o,
  output logic        byte_last_o,
  output logic        grey_strobe_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  grey_map_t    grey_q;
  logic         cfg_we;

  logic         push;
  cmd_t         push_cmd;
  cmd_t         head_cmd;
  logic         q_empty;
  logic         q_full;
  logic         pop;
  back_status_t back_status;

  // Level registers: word address selects the level, only the low nibble
  // is kept.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = {28'd0, grey_q[paddr[3:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grey_q <= GREY_RESET;
    end else if (cfg_we) begin
      grey_q[paddr[3:2]] <= pwdata[3:0];
    end
  end

  // front: range checks, span clipping, queue push
  gfs_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_level_i  (pixel_level_i),
    .span_row_i     (span_row_i),
    .first_column_i (first_column_i),
    .last_column_i  (last_column_i),
    .queue_full_i   (q_full),
    .back_status_i  (back_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // command queue decoupling front and back
  gfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: frame memory, write merge, span readout, clear sweep
  gfs_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .cmd_i         (head_cmd),
    .grey_map_i    (grey_q),
    .pop_o         (pop),
    .status_o      (back_status),
    .grey_byte_o   (grey_byte_o),
    .byte_last_o   (byte_last_o),
    .grey_strobe_o (grey_strobe_o)
  );

endmodule
